// ----- src/fls_pkg.sv -----
// Shared constants, types and register codes of the flat face shader.
`timescale 1ns / 1ps
package fls_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  localparam int MAG_W     = 30;
  localparam int SUM_W     = 2 * MAG_W + 2;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int Q_W       = 15;
  localparam int NORM_W    = 16;
  localparam int LIGHT_W   = 16;
  localparam int AMB_W     = 9;
  localparam int COLOR_W   = 8;
  localparam int LPROD_W   = NORM_W + LIGHT_W;
  localparam int DOT_W     = LPROD_W + 2;
  localparam int STR_FRAC  = 28;
  localparam int STR_W     = STR_FRAC + 1;
  localparam int AMB_SHIFT = 20;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic signed [NORM_W-1:0] UNIT_NORM = NORM_W'(16384);
  localparam logic [STR_W-1:0] STR_MAX = STR_W'(1) << STR_FRAC;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LIGHT_X,
    REG_LIGHT_Y,
    REG_LIGHT_Z,
    REG_AMBIENT_LEVEL,
    REG_OBJECT_RED,
    REG_OBJECT_GREEN,
    REG_OBJECT_BLUE
  } fls_reg_t;

  typedef struct packed {
    logic signed [LIGHT_W-1:0] light_x;
    logic signed [LIGHT_W-1:0] light_y;
    logic signed [LIGHT_W-1:0] light_z;
    logic [AMB_W-1:0]          ambient_level;
    logic [COLOR_W-1:0]        object_red;
    logic [COLOR_W-1:0]        object_green;
    logic [COLOR_W-1:0]        object_blue;
  } fls_cfg_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       flip;
    logic       zero;
  } fls_sign_t;

endpackage

// ----- src/flat_face_shader_core.sv -----
// Top level of the flat face shader: register file, stall control and pipeline.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  in       | in_valid / in_stall     | first_x .. third_z (signed Q16.16)
//  out      | out_valid / out_stall   | normal_x/y/z, shade_red/green/blue,
//           |                         | degenerate
//  cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One triangle request enters per cycle while the output is not stalled; each passes
// the cross product, normalizing and the orientation test, the square-root stages,
// the divider stages and shading up to the output register.
// Reset clears every valid bit and loads the register reset values.
// Stalling a valid output freezes the pipeline and stalls the input in the same cycle.
`timescale 1ns / 1ps
module flat_face_shader_core import fls_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] first_z,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] second_z,
  input  logic signed [COORD_WIDTH-1:0] third_x,
  input  logic signed [COORD_WIDTH-1:0] third_y,
  input  logic signed [COORD_WIDTH-1:0] third_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [NORM_W-1:0]      normal_x,
  output logic signed [NORM_W-1:0]      normal_y,
  output logic signed [NORM_W-1:0]      normal_z,
  output logic [COLOR_W-1:0]            shade_red,
  output logic [COLOR_W-1:0]            shade_green,
  output logic [COLOR_W-1:0]            shade_blue,
  output logic                          degenerate,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int XW   = 2 * CW + 3;
  localparam int SG_W = $bits(fls_sign_t);

  fls_cfg_t cfg;
  logic     en;

  logic signed [CW-1:0] p [9];

  logic                 v_c;
  logic [XW-1:0]        a_c [3];
  logic [2:0]           sgn_c;
  logic signed [CW+1:0] s_c [3];

  logic                 v_n;
  logic [SUM_W-1:0]     sum_n;
  logic [MAG_W-1:0]     mg_n [3];
  fls_sign_t            sign_n;

  logic                 v_r;
  logic [ROOT_W-1:0]    root_r;
  logic [MAG_W-1:0]     mg_r [3];
  fls_sign_t            sign_r;

  logic                 v_q;
  logic [Q_W-1:0]       q_q [3];
  fls_sign_t            sign_q;

  logic signed [NORM_W-1:0] normal [3];
  logic [COLOR_W-1:0]       shade [3];

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  assign p = '{first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.light_x       <= '0;
      cfg.light_y       <= '0;
      cfg.light_z       <= UNIT_NORM;
      cfg.ambient_level <= AMB_W'(128);
      cfg.object_red    <= '1;
      cfg.object_green  <= '1;
      cfg.object_blue   <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LIGHT_X:       cfg.light_x       <= cfg_data;
        REG_LIGHT_Y:       cfg.light_y       <= cfg_data;
        REG_LIGHT_Z:       cfg.light_z       <= cfg_data;
        REG_AMBIENT_LEVEL: cfg.ambient_level <= cfg_data[AMB_W-1:0];
        REG_OBJECT_RED:    cfg.object_red    <= cfg_data[COLOR_W-1:0];
        REG_OBJECT_GREEN:  cfg.object_green  <= cfg_data[COLOR_W-1:0];
        REG_OBJECT_BLUE:   cfg.object_blue   <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  fls_cross #(.CW(CW)) u_cross (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .p         (p),
    .out_valid (v_c),
    .a         (a_c),
    .sgn       (sgn_c),
    .s         (s_c)
  );

  fls_norm #(.CW(CW)) u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_c),
    .a         (a_c),
    .sgn       (sgn_c),
    .s         (s_c),
    .out_valid (v_n),
    .sum       (sum_n),
    .mg        (mg_n),
    .sign      (sign_n)
  );

  fls_sqrt #(.IW(SUM_W), .SIDE_W(3 * MAG_W + SG_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_n),
    .x         (sum_n),
    .side      ({mg_n[0], mg_n[1], mg_n[2], sign_n}),
    .out_valid (v_r),
    .root      (root_r),
    .side_out  ({mg_r[0], mg_r[1], mg_r[2], sign_r})
  );

  fls_div #(.SIDE_W(SG_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_r),
    .mg        (mg_r),
    .mag       (root_r),
    .side      (sign_r),
    .out_valid (v_q),
    .q         (q_q),
    .side_out  (sign_q)
  );

  fls_shade u_shade (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (v_q),
    .q          (q_q),
    .sign       (sign_q),
    .cfg        (cfg),
    .out_valid  (out_valid),
    .normal     (normal),
    .shade      (shade),
    .degenerate (degenerate)
  );

  assign normal_x    = normal[0];
  assign normal_y    = normal[1];
  assign normal_z    = normal[2];
  assign shade_red   = shade[0];
  assign shade_green = shade[1];
  assign shade_blue  = shade[2];

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0
      && shade_red == '0 && shade_green == '0 && shade_blue == '0)
    else $error("degenerate face with nonzero normal or color");

  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> normal_x <= UNIT_NORM && normal_x >= -UNIT_NORM
      && normal_y <= UNIT_NORM && normal_y >= -UNIT_NORM
      && normal_z <= UNIT_NORM && normal_z >= -UNIT_NORM)
    else $error("normal component beyond unit length");

  a_shade_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> shade_red <= cfg.object_red && shade_green <= cfg.object_green
      && shade_blue <= cfg.object_blue)
    else $error("shaded color brighter than object color");

endmodule

// ----- src/fls_cross.sv -----
// Edge vectors, vertex sum, exact cross product and its sign and magnitude.
`timescale 1ns / 1ps
module fls_cross import fls_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [CW-1:0]   p [9],
  output logic                   out_valid,
  output logic [2*CW+2:0]        a [3],
  output logic [2:0]             sgn,
  output logic signed [CW+1:0]   s [3]
);

  localparam int EW = CW + 1;
  localparam int SW = CW + 2;
  localparam int PW = 2 * EW;
  localparam int XW = PW + 1;

  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [SW-1:0] s_a [3];
  logic                 v_a;

  logic signed [PW-1:0] pr [6];
  logic signed [SW-1:0] s_b [3];
  logic                 v_b;

  logic signed [XW-1:0] c [3];

  always_comb begin
    c[0] = $signed({pr[0][PW-1], pr[0]}) - $signed({pr[1][PW-1], pr[1]});
    c[1] = $signed({pr[2][PW-1], pr[2]}) - $signed({pr[3][PW-1], pr[3]});
    c[2] = $signed({pr[4][PW-1], pr[4]}) - $signed({pr[5][PW-1], pr[5]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a       <= 1'b0;
      v_b       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_a       <= in_valid;
      v_b       <= v_a;
      out_valid <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1[i]  <= $signed({p[3+i][CW-1], p[3+i]}) - $signed({p[i][CW-1], p[i]});
        e2[i]  <= $signed({p[6+i][CW-1], p[6+i]}) - $signed({p[i][CW-1], p[i]});
        s_a[i] <= $signed({{2{p[i][CW-1]}}, p[i]}) + $signed({{2{p[3+i][CW-1]}}, p[3+i]})
                + $signed({{2{p[6+i][CW-1]}}, p[6+i]});
      end
      pr[0] <= e1[1] * e2[2];
      pr[1] <= e1[2] * e2[1];
      pr[2] <= e1[2] * e2[0];
      pr[3] <= e1[0] * e2[2];
      pr[4] <= e1[0] * e2[1];
      pr[5] <= e1[1] * e2[0];
      s_b   <= s_a;
      for (int i = 0; i < 3; i++) begin
        sgn[i] <= c[i][XW-1];
        a[i]   <= c[i][XW-1] ? XW'(-c[i]) : XW'(c[i]);
      end
      s <= s_b;
    end
  end

endmodule

// ----- src/fls_norm.sv -----
// Common normalizing shift to 30 bits, squared length and orientation test.
`timescale 1ns / 1ps
module fls_norm import fls_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2*CW+2:0]       a [3],
  input  logic [2:0]            sgn,
  input  logic signed [CW+1:0]  s [3],
  output logic                  out_valid,
  output logic [SUM_W-1:0]      sum,
  output logic [MAG_W-1:0]      mg [3],
  output fls_sign_t             sign
);

  localparam int SW  = CW + 2;
  localparam int XW  = 2 * CW + 3;
  localparam int LW  = $clog2(XW + 1);
  localparam int DW  = SW + MAG_W + 1;
  localparam int DSW = DW + 2;

  logic [XW-1:0]        a_d [3];
  logic [2:0]           sgn_d;
  logic signed [SW-1:0] s_d [3];
  logic [XW-1:0]        orw_d;
  logic                 v_d;

  logic [LW-1:0]        l_next;
  logic [LW-1:0]        l_e;
  logic                 zero_e;
  logic [XW-1:0]        a_e [3];
  logic [2:0]           sgn_e;
  logic signed [SW-1:0] s_e [3];
  logic                 v_e;

  logic [XW+MAG_W-1:0]  wide [3];
  logic [MAG_W-1:0]     mg_f [3];
  logic signed [MAG_W:0] m_f [3];
  logic [2:0]           sgn_f;
  logic signed [SW-1:0] s_f [3];
  logic                 zero_f;
  logic                 v_f;

  logic [2*MAG_W-1:0]   sq_g [3];
  logic signed [DW-1:0] dp_g [3];
  logic [MAG_W-1:0]     mg_g [3];
  logic [2:0]           sgn_g;
  logic                 zero_g;
  logic                 v_g;

  logic signed [DSW-1:0] dot;

  always_comb begin
    l_next = '0;
    for (int k = 0; k < XW; k++) begin
      if (orw_d[k]) l_next = LW'(k + 1);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) wide[i] = {a_e[i], {MAG_W{1'b0}}} >> l_e;
  end

  assign dot = DSW'(dp_g[0]) + DSW'(dp_g[1]) + DSW'(dp_g[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d       <= 1'b0;
      v_e       <= 1'b0;
      v_f       <= 1'b0;
      v_g       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_d       <= in_valid;
      v_e       <= v_d;
      v_f       <= v_e;
      v_g       <= v_f;
      out_valid <= v_g;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d    <= a;
      sgn_d  <= sgn;
      s_d    <= s;
      orw_d  <= a[0] | a[1] | a[2];

      l_e    <= l_next;
      zero_e <= (orw_d == '0);
      a_e    <= a_d;
      sgn_e  <= sgn_d;
      s_e    <= s_d;

      for (int i = 0; i < 3; i++) begin
        mg_f[i] <= wide[i][MAG_W-1:0];
        m_f[i]  <= sgn_e[i] ? -$signed({1'b0, wide[i][MAG_W-1:0]})
                            : $signed({1'b0, wide[i][MAG_W-1:0]});
      end
      sgn_f  <= sgn_e;
      s_f    <= s_e;
      zero_f <= zero_e;

      for (int i = 0; i < 3; i++) begin
        sq_g[i] <= mg_f[i] * mg_f[i];
        dp_g[i] <= s_f[i] * m_f[i];
      end
      mg_g   <= mg_f;
      sgn_g  <= sgn_f;
      zero_g <= zero_f;

      sum       <= SUM_W'(sq_g[0]) + SUM_W'(sq_g[1]) + SUM_W'(sq_g[2]);
      mg        <= mg_g;
      sign.neg  <= sgn_g;
      sign.flip <= dot[DSW-1];
      sign.zero <= zero_g;
    end
  end

endmodule

// ----- src/fls_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, with a carried sideband.
`timescale 1ns / 1ps
module fls_sqrt #(
  parameter int IW     = 62,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IW-1:0]     x,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [IW/2-1:0]   root,
  output logic [SIDE_W-1:0] side_out
);

  localparam int NS = IW / 2;

  logic [IW-1:0]     xs [NS];
  logic [IW:0]       rs [NS];
  logic [SIDE_W-1:0] ss [NS];
  logic              vs [NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    localparam int K = NS - 1 - j;
    localparam logic [IW:0] BIT = (IW + 1)'(1) << (2 * K);

    logic [IW-1:0]     x_in;
    logic [IW:0]       r_in;
    logic [SIDE_W-1:0] s_in;
    logic              v_in;
    logic [IW:0]       trial;

    if (j == 0) begin : g_first
      always_comb begin
        x_in = x;
        r_in = '0;
        s_in = side;
        v_in = in_valid;
      end
    end else begin : g_next
      always_comb begin
        x_in = xs[j-1];
        r_in = rs[j-1];
        s_in = ss[j-1];
        v_in = vs[j-1];
      end
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[j] <= 1'b0;
      end else if (en) begin
        vs[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ss[j] <= s_in;
        if ({1'b0, x_in} >= trial) begin
          xs[j] <= x_in - trial[IW-1:0];
          rs[j] <= (r_in >> 1) + BIT;
        end else begin
          xs[j] <= x_in;
          rs[j] <= r_in >> 1;
        end
      end
    end
  end

  assign out_valid = vs[NS-1];
  assign root      = rs[NS-1][NS-1:0];
  assign side_out  = ss[NS-1];

endmodule

// ----- src/fls_div.sv -----
// Three-lane pipelined restoring divider giving the rounded unit normal magnitudes.
`timescale 1ns / 1ps
module fls_div import fls_pkg::*; #(
  parameter int SIDE_W = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [MAG_W-1:0]  mg [3],
  input  logic [ROOT_W-1:0] mag,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [Q_W-1:0]    q [3],
  output logic [SIDE_W-1:0] side_out
);

  localparam int RW  = ROOT_W + Q_W;
  localparam int DVW = ROOT_W + 1;

  logic [RW-1:0]     rem [Q_W][3];
  logic [DVW-1:0]    dv  [Q_W][3];
  logic [Q_W-1:0]    qv  [Q_W][3];
  logic [SIDE_W-1:0] ss  [Q_W];
  logic              vs  [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    localparam int K = Q_W - 1 - j;

    logic [RW-1:0]     rem_in [3];
    logic [DVW-1:0]    dv_in  [3];
    logic [Q_W-1:0]    q_in   [3];
    logic [SIDE_W-1:0] s_in;
    logic              v_in;
    logic [RW-1:0]     ds     [3];

    if (j == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = RW'({mg[i], {Q_W{1'b0}}}) + RW'(mag);
          dv_in[i]  = {mag, 1'b0};
          q_in[i]   = '0;
        end
        s_in = side;
        v_in = in_valid;
      end
    end else begin : g_next
      always_comb begin
        rem_in = rem[j-1];
        dv_in  = dv[j-1];
        q_in   = qv[j-1];
        s_in   = ss[j-1];
        v_in   = vs[j-1];
      end
    end

    always_comb begin
      for (int i = 0; i < 3; i++) ds[i] = RW'(dv_in[i]) << K;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[j] <= 1'b0;
      end else if (en) begin
        vs[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ss[j] <= s_in;
        dv[j] <= dv_in;
        for (int i = 0; i < 3; i++) begin
          if (rem_in[i] >= ds[i]) begin
            rem[j][i] <= rem_in[i] - ds[i];
            qv[j][i]  <= q_in[i] | (Q_W'(1) << K);
          end else begin
            rem[j][i] <= rem_in[i];
            qv[j][i]  <= q_in[i];
          end
        end
      end
    end
  end

  assign out_valid = vs[Q_W-1];
  assign q         = qv[Q_W-1];
  assign side_out  = ss[Q_W-1];

endmodule

// ----- src/fls_shade.sv -----
// Signed normal, Lambert plus ambient strength and color scaling into the output register.
`timescale 1ns / 1ps
module fls_shade import fls_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [Q_W-1:0]           q [3],
  input  fls_sign_t                sign,
  input  fls_cfg_t                 cfg,
  output logic                     out_valid,
  output logic signed [NORM_W-1:0] normal [3],
  output logic [COLOR_W-1:0]       shade [3],
  output logic                     degenerate
);

  localparam int SR_W = STR_W + 6;
  localparam int CP_W = STR_W + COLOR_W;

  logic signed [NORM_W-1:0]  n1 [3];
  logic                      zero1;
  logic                      v1;

  logic signed [LPROD_W-1:0] lp2 [3];
  logic signed [NORM_W-1:0]  n2 [3];
  logic                      zero2;
  logic                      v2;

  logic signed [NORM_W-1:0]  n3 [3];
  logic [STR_W-1:0]          str3;
  logic                      zero3;
  logic                      v3;

  logic signed [LIGHT_W-1:0] light [3];
  logic [COLOR_W-1:0]        color [3];
  logic signed [DOT_W-1:0]   dsum;
  logic [SR_W-1:0]           sraw;
  logic [CP_W-1:0]           cp [3];

  assign light = '{cfg.light_x, cfg.light_y, cfg.light_z};
  assign color = '{cfg.object_red, cfg.object_green, cfg.object_blue};

  always_comb begin
    dsum = DOT_W'(lp2[0]) + DOT_W'(lp2[1]) + DOT_W'(lp2[2]);
    sraw = SR_W'({cfg.ambient_level, {AMB_SHIFT{1'b0}}});
    if (!dsum[DOT_W-1]) sraw = sraw + SR_W'(dsum);
    for (int i = 0; i < 3; i++) cp[i] = CP_W'(str3) * CP_W'(color[i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (sign.zero) begin
          n1[i] <= '0;
        end else if (sign.neg[i] ^ sign.flip) begin
          n1[i] <= -$signed({1'b0, q[i]});
        end else begin
          n1[i] <= $signed({1'b0, q[i]});
        end
      end
      zero1 <= sign.zero;

      for (int i = 0; i < 3; i++) lp2[i] <= light[i] * n1[i];
      n2    <= n1;
      zero2 <= zero1;

      str3  <= (sraw > SR_W'(STR_MAX)) ? STR_MAX : sraw[STR_W-1:0];
      n3    <= n2;
      zero3 <= zero2;

      for (int i = 0; i < 3; i++) begin
        shade[i] <= zero3 ? '0 : cp[i][STR_FRAC+COLOR_W-1:STR_FRAC];
      end
      normal     <= n3;
      degenerate <= zero3;
    end
  end

endmodule

// ----- tb/flat_face_shader_checker.sv -----
// Checker for the flat face shader: watches the channels, predicts each face and compares.
`timescale 1ns / 1ps
module flat_face_shader_checker import fls_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic signed [31:0]     first_x,
  input  logic signed [31:0]     first_y,
  input  logic signed [31:0]     first_z,
  input  logic signed [31:0]     second_x,
  input  logic signed [31:0]     second_y,
  input  logic signed [31:0]     second_z,
  input  logic signed [31:0]     third_x,
  input  logic signed [31:0]     third_y,
  input  logic signed [31:0]     third_z,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic signed [15:0]     normal_x,
  input  logic signed [15:0]     normal_y,
  input  logic signed [15:0]     normal_z,
  input  logic [7:0]             shade_red,
  input  logic [7:0]             shade_green,
  input  logic [7:0]             shade_blue,
  input  logic                   degenerate,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fails,
  output int                     pending
);

  typedef struct {
    logic signed [15:0] nx, ny, nz;
    logic [7:0]         r, g, b;
    logic               degen;
  } face_t;

  fls_cfg_t shader_cfg;
  face_t    expected_faces[$];

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, bits;
    r = 0;
    bits = 64'd1 << 62;
    while (bits > x) bits = bits >> 2;
    while (bits != 0) begin
      if (x >= r + bits) begin
        x = x - (r + bits);
        r = (r >> 1) + bits;
      end else begin
        r = r >> 1;
      end
      bits = bits >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] color_scale(logic signed [63:0] strength,
                                                      logic [7:0] color);
    logic [63:0] prod;
    prod = 64'(strength) * 64'(color);
    return (prod >> 28) & 64'hFF;
  endfunction

  function automatic face_t shade_face(logic signed [127:0] p[9]);
    logic signed [127:0] e1[3], e2[3], s[3], c[3], m[3], dot;
    logic [127:0]        a[3], sh;
    logic [63:0]         mg[3], sum, mag, q;
    logic signed [63:0]  nrm[3], d, strength;
    logic                flip, mneg;
    int                  top_bit, i, k;
    face_t               f;
    f = '{default: 0};
    for (i = 0; i < 3; i++) begin
      e1[i] = p[3 + i] - p[i];
      e2[i] = p[6 + i] - p[i];
      s[i]  = p[i] + p[3 + i] + p[6 + i];
    end
    c[0] = e1[1] * e2[2] - e1[2] * e2[1];
    c[1] = e1[2] * e2[0] - e1[0] * e2[2];
    c[2] = e1[0] * e2[1] - e1[1] * e2[0];
    top_bit = 0;
    for (i = 0; i < 3; i++) begin
      a[i] = c[i] < 0 ? -c[i] : c[i];
      for (k = 127; k >= 0; k--) begin
        if (a[i][k]) begin
          if (k + 1 > top_bit) top_bit = k + 1;
          break;
        end
      end
    end
    if (top_bit == 0) begin
      f.degen = 1;
      return f;
    end
    sum = 0;
    for (i = 0; i < 3; i++) begin
      sh = top_bit >= 30 ? a[i] >> (top_bit - 30) : a[i] << (30 - top_bit);
      mg[i] = sh[63:0];
      m[i] = (c[i] < 0) ? -$signed({64'd0, mg[i]}) : $signed({64'd0, mg[i]});
      sum = sum + mg[i] * mg[i];
    end
    mag = int_sqrt(sum);
    dot = s[0] * m[0] + s[1] * m[1] + s[2] * m[2];
    flip = dot < 0;
    for (i = 0; i < 3; i++) begin
      q = (mg[i] * 64'd32768 + mag) / (64'd2 * mag);
      mneg = m[i] < 0;
      nrm[i] = (mneg != flip) ? -$signed(q) : $signed(q);
    end
    f.nx = nrm[0][15:0];
    f.ny = nrm[1][15:0];
    f.nz = nrm[2][15:0];
    d = 64'(shader_cfg.light_x) * nrm[0] + 64'(shader_cfg.light_y) * nrm[1]
      + 64'(shader_cfg.light_z) * nrm[2];
    if (d < 0) d = 0;
    strength = $signed({35'd0, shader_cfg.ambient_level, 20'd0}) + d;
    if (strength > (64'sd1 <<< 28)) strength = 64'sd1 <<< 28;
    f.r = 8'(color_scale(strength, shader_cfg.object_red));
    f.g = 8'(color_scale(strength, shader_cfg.object_green));
    f.b = 8'(color_scale(strength, shader_cfg.object_blue));
    return f;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      fails++;
    end
  endtask

  initial fails = 0;
  assign pending = expected_faces.size();

  always @(posedge clk) begin
    logic signed [127:0] pts[9];
    face_t want;
    if (rst) begin
      shader_cfg <= '{light_x: 16'sd0, light_y: 16'sd0, light_z: 16'sd16384,
                      ambient_level: 9'd128, object_red: 8'd255,
                      object_green: 8'd255, object_blue: 8'd255};
      expected_faces.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (fls_reg_t'(cfg_index))
          REG_LIGHT_X:       shader_cfg.light_x <= cfg_data;
          REG_LIGHT_Y:       shader_cfg.light_y <= cfg_data;
          REG_LIGHT_Z:       shader_cfg.light_z <= cfg_data;
          REG_AMBIENT_LEVEL: shader_cfg.ambient_level <= cfg_data[AMB_W-1:0];
          REG_OBJECT_RED:    shader_cfg.object_red <= cfg_data[7:0];
          REG_OBJECT_GREEN:  shader_cfg.object_green <= cfg_data[7:0];
          REG_OBJECT_BLUE:   shader_cfg.object_blue <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pts[0] = first_x;  pts[1] = first_y;  pts[2] = first_z;
        pts[3] = second_x; pts[4] = second_y; pts[5] = second_z;
        pts[6] = third_x;  pts[7] = third_y;  pts[8] = third_z;
        expected_faces.insert(expected_faces.size(), shade_face(pts));
      end
      if (out_valid && !out_stall) begin
        if (expected_faces.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual normal %0d %0d %0d",
                   $realtime, normal_x, normal_y, normal_z);
          fails++;
        end else begin
          want = expected_faces.pop_front();
          check_field("normal_x", want.nx, normal_x);
          check_field("normal_y", want.ny, normal_y);
          check_field("normal_z", want.nz, normal_z);
          check_field("shade_red", want.r, shade_red);
          check_field("shade_green", want.g, shade_green);
          check_field("shade_blue", want.b, shade_blue);
          check_field("degenerate", want.degen, degenerate);
        end
      end
    end
  end

endmodule

// ----- tb/flat_face_shader_core_tb.sv -----
// Testbench top for the flat face shader: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module flat_face_shader_core_tb;
  import fls_pkg::*;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic signed [31:0] first_x = 0, first_y = 0, first_z = 0;
  logic signed [31:0] second_x = 0, second_y = 0, second_z = 0;
  logic signed [31:0] third_x = 0, third_y = 0, third_z = 0;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic [7:0] shade_red, shade_green, shade_blue;
  logic degenerate;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = 0;
  logic [CFG_DATA_W-1:0] cfg_data = 0;
  int fails, pending;
  int sent = 0;
  int rx_cycle = 0;
  int hold_cnt = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  flat_face_shader_core dut (.*);
  flat_face_shader_checker checker_i (.*);

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_cnt == 0 && sent >= 700) hold_cnt <= 1;
      else if (hold_cnt > 0 && hold_cnt < 300) hold_cnt <= hold_cnt + 1;
      if (hold_cnt > 0 && hold_cnt < 300) out_stall <= 1;
      else if (rx_cycle >= 600 && rx_cycle < 1000) out_stall <= 0;
      else out_stall <= ($urandom_range(99) < 26);
    end
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic write_all(logic [15:0] lx, logic [15:0] ly, logic [15:0] lz,
                           logic [15:0] amb, logic [15:0] r, logic [15:0] g,
                           logic [15:0] b);
    write_reg(REG_LIGHT_X, lx);
    write_reg(REG_LIGHT_Y, ly);
    write_reg(REG_LIGHT_Z, lz);
    write_reg(REG_AMBIENT_LEVEL, amb);
    write_reg(REG_OBJECT_RED, r);
    write_reg(REG_OBJECT_GREEN, g);
    write_reg(REG_OBJECT_BLUE, b);
    write_reg(3'd7, 16'($urandom));
    @(posedge clk);
  endtask

  task automatic send_face(logic signed [31:0] v[9]);
    while (!(sent >= 400 && sent < 600) && $urandom_range(99) < 26) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    first_x  <= v[0]; first_y  <= v[1]; first_z  <= v[2];
    second_x <= v[3]; second_y <= v[4]; second_z <= v[5];
    third_x  <= v[6]; third_y  <= v[7]; third_z  <= v[8];
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(2000)) - 1000;
      2: return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
      default: return $signed($urandom_range(8)) - 4;
    endcase
  endfunction

  task automatic send_random;
    logic signed [31:0] v[9];
    int mode, i, t;
    mode = $urandom_range(3);
    for (i = 0; i < 9; i++) v[i] = rand_coord(mode);
    case ($urandom_range(9))
      0: for (i = 0; i < 3; i++) v[3 + i] = v[i];
      1: for (i = 0; i < 3; i++) begin
        t = $signed($urandom_range(6)) - 3;
        v[6 + i] = v[i] + t * (v[3 + i] - v[i]);
      end
      default: ;
    endcase
    send_face(v);
  endtask

  initial begin
    logic signed [31:0] d[9];
    int k, ph;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_all(16'h0000, 16'h0000, 16'h4000, 16'd128, 16'd255, 16'd255, 16'd255);
    d = '{default: 32'sh7FFF_FFFF};                                      send_face(d);
    d = '{default: 32'sh8000_0000};                                      send_face(d);
    d = '{0, 0, 0, 32'sh1_0000, 0, 0, 0, 32'sh1_0000, 0};                send_face(d);
    d = '{0, 0, 0, 0, 32'sh1_0000, 0, 32'sh1_0000, 0, 0};                send_face(d);
    d = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
          32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
          32'sh7FFF_FFFF};                                               send_face(d);
    d = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh8000_0000,
          32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000};         send_face(d);
    d = '{0, 0, 5, 1, 0, 5, 0, 1, 5};                                    send_face(d);
    d = '{0, 0, -5, 0, 1, -5, 1, 0, -5};                                 send_face(d);
    d = '{1, 0, 0, -1, 0, 0, 0, 1, 0};                                   send_face(d);
    d = '{1, 2, 3, 2, 4, 6, 3, 6, 9};                                    send_face(d);
    d = '{-1, 1, 0, 1, -1, 0, 0, 0, 1};                                  send_face(d);
    d = '{32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 32'sh2_0000, 32'sh1_0000,
          32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 32'sh3_0000};           send_face(d);
    drain();
    write_all(16'h4000, 16'h0000, 16'h0000, 16'd0, 16'd0, 16'd255, 16'd128);
    d = '{0, 0, 0, 0, 32'sh1_0000, 0, 0, 0, 32'sh1_0000};                send_face(d);
    d = '{0, 0, 0, 0, 0, 32'sh1_0000, 0, 32'sh1_0000, 0};                send_face(d);
    drain();
    write_all(16'hC000, 16'hC000, 16'hC000, 16'd256, 16'd1, 16'd2, 16'd3);
    d = '{0, 0, 0, 32'sh1_0000, 0, 0, 0, 32'sh1_0000, 0};                send_face(d);
    d = '{0, 0, 0, 0, 32'sh1_0000, 0, 32'sh1_0000, 0, 0};                send_face(d);
    drain();
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_all(16'h2D41, 16'hD2BF, 16'h0000, 16'd64, 16'd200, 16'd100, 16'd50);
        1: write_all(16'h7FFF, 16'h8000, 16'h7FFF, 16'd511, 16'd255, 16'd0, 16'd255);
        2: write_all(16'h8000, 16'h8000, 16'h8000, 16'd0, 16'd255, 16'd255, 16'd255);
        default: write_all(16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom_range(300)), 16'($urandom_range(255)),
                           16'($urandom_range(255)), 16'($urandom_range(255)));
      endcase
      for (k = 0; k < 200; k++) send_random();
      drain();
    end
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/fls_pkg.sv
src/fls_cross.sv
src/fls_norm.sv
src/fls_sqrt.sv
src/fls_div.sv
src/fls_shade.sv
src/flat_face_shader_core.sv
tb/flat_face_shader_checker.sv
tb/flat_face_shader_core_tb.sv
